// File: src/rrt_pkg.sv
// Shared types and constants for the round-robin turn ring.
// Holds operation and status codes, sequencer states and the result bundle.
// No dependencies.
package rrt_pkg;

  localparam int ID_W    = 16;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_SKIP    = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_FIX,
    S_TURN_RD,
    S_SKIP_RD,
    S_REM_HEAD,
    S_REM_WALK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic               done;
    status_t            status;
    logic [ID_W-1:0]    announced_id;
    logic [ID_W-1:0]    following_id;
    logic [COUNT_W-1:0] member_count;
    logic               winner_valid;
    logic [ID_W-1:0]    winner_id;
  } result_t;

endpackage

// File: src/round_robin_turn_ring_top.sv
// Top level of the round-robin turn ring.
// Depends on rrt_pkg and rrt_engine (which holds rrt_slot_mem).
//
// Usage:
//   Command channel: drive in_operation and in_player_id with start high;
//   the command transfers at a rising edge where start is high and busy is
//   low. busy stays high until the command has finished.
//   Result channel: each command yields exactly one result, shown on the
//   out_ ports for one cycle with out_valid high. The receiver cannot stall;
//   it must take the result in that cycle.
//   Work per command: advance reads one slot, skip reads two, add scans
//   up to the lowest free slot, remove walks at most the whole ring, and
//   errors go straight to the result.
//   One command is in flight at a time; the next may transfer in the cycle
//   the result is shown. The remove walk and the free-slot scan take one
//   slot per cycle; the walk reads the slots through the single read port.
//   Reset (rst_n low, synchronous) empties the ring and drops any command.
module round_robin_turn_ring_top
  import rrt_pkg::*;
#(
  parameter int MAX_MEMBERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ID_W-1:0]    in_player_id,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [ID_W-1:0]    out_announced_id,
  output logic [ID_W-1:0]    out_following_id,
  output logic [COUNT_W-1:0] out_member_count,
  output logic               out_winner_valid,
  output logic [ID_W-1:0]    out_winner_id
);

  result_t result;
  logic    out_valid_r;
  result_t out_r;

  rrt_engine #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op_in  (in_operation),
    .id_in  (in_player_id),
    .busy   (busy),
    .result (result)
  );

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= result.done;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (result.done) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_announced_id = out_r.announced_id;
  assign out_following_id = out_r.following_id;
  assign out_member_count = out_r.member_count;
  assign out_winner_valid = out_r.winner_valid;
  assign out_winner_id    = out_r.winner_id;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a command in flight");
`endif

endmodule

// File: src/rrt_slot_mem.sv
// Slot storage for the turn ring: member ID and next-slot link per slot.
// One write port with separate enables, one registered read port.
// Depends on rrt_pkg.
module rrt_slot_mem
  import rrt_pkg::*;
#(
  parameter int MAX_MEMBERS = 16,
  parameter int SW          = (MAX_MEMBERS > 2) ? $clog2(MAX_MEMBERS) : 1
) (
  input  logic            clk,
  input  logic            we_member,
  input  logic            we_link,
  input  logic [SW-1:0]   wr_addr,
  input  logic [ID_W-1:0] wr_member,
  input  logic [SW-1:0]   wr_link,
  input  logic            rd_en,
  input  logic [SW-1:0]   rd_addr,
  output logic [ID_W-1:0] rd_member,
  output logic [SW-1:0]   rd_link
);

  logic [ID_W-1:0] member_mem [MAX_MEMBERS];
  logic [SW-1:0]   link_mem   [MAX_MEMBERS];
  logic [ID_W-1:0] rd_member_r;
  logic [SW-1:0]   rd_link_r;

  // Write the selected fields of one slot
  always_ff @(posedge clk) begin
    if (we_member) begin
      member_mem[wr_addr] <= wr_member;
    end
    if (we_link) begin
      link_mem[wr_addr] <= wr_link;
    end
  end

  // Read one slot; hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_member_r <= member_mem[rd_addr];
      rd_link_r   <= link_mem[rd_addr];
    end
  end

  assign rd_member = rd_member_r;
  assign rd_link   = rd_link_r;

endmodule

// File: src/rrt_engine.sv
// Sequencer and ring state for the turn ring: walks the slot links one
// step per cycle through the shared read port and ID comparator.
// Depends on rrt_pkg and rrt_slot_mem.
module rrt_engine
  import rrt_pkg::*;
#(
  parameter int MAX_MEMBERS = 16,
  parameter int SW          = (MAX_MEMBERS > 2) ? $clog2(MAX_MEMBERS) : 1,
  parameter int CW          = $clog2(MAX_MEMBERS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] op_in,
  input  logic [ID_W-1:0] id_in,
  output logic            busy,
  output result_t         result
);

  state_t          state_r, state_nxt;
  op_t             op_r, op_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  status_t         status_r, status_nxt;
  logic [ID_W-1:0] ann_r, ann_nxt;
  logic [ID_W-1:0] fol_r, fol_nxt;
  logic [CW-1:0]   size_r, size_nxt;
  logic [SW-1:0]   newest_r, newest_nxt;
  logic [ID_W-1:0] newest_id_r, newest_id_nxt;
  logic [SW-1:0]   turn_r, turn_nxt;
  logic [SW-1:0]   prev_r, prev_nxt;
  logic [ID_W-1:0] prev_id_r, prev_id_nxt;
  logic [SW-1:0]   cur_r, cur_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [SW-1:0]   free_r, free_nxt;
  logic [MAX_MEMBERS-1:0] in_use_r, in_use_nxt;

  logic            we_member, we_link, rd_en;
  logic [SW-1:0]   wr_addr, wr_link, rd_addr;
  logic [ID_W-1:0] wr_member, rd_member;
  logic [SW-1:0]   rd_link;

  logic accept, ring_empty, ring_full, free_hit, id_hit, walk_last;
  op_t  op_cmd;

  rrt_slot_mem #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .SW          (SW)
  ) u_mem (
    .clk       (clk),
    .we_member (we_member),
    .we_link   (we_link),
    .wr_addr   (wr_addr),
    .wr_member (wr_member),
    .wr_link   (wr_link),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_member (rd_member),
    .rd_link   (rd_link)
  );

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign op_cmd     = op_t'(op_in);
  assign ring_empty = (size_r == '0);
  assign ring_full  = (size_r == CW'(MAX_MEMBERS));
  assign free_hit   = !in_use_r[cnt_r];
  // Shared comparator: slot ID against the requested ID
  assign id_hit     = (rd_member == id_r);
  assign walk_last  = ((n_r + CW'(1)) == size_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_cmd)
            OP_ADD:    state_nxt = ring_full ? S_RESULT : S_ADD_SCAN;
            OP_REMOVE: state_nxt = ring_empty ? S_RESULT : S_REM_HEAD;
            default:   state_nxt = ring_empty ? S_RESULT : S_TURN_RD;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (free_hit) begin
          state_nxt = ring_empty ? S_RESULT : S_ADD_FIX;
        end
      end
      S_ADD_FIX:  state_nxt = S_RESULT;
      S_TURN_RD:  state_nxt = (op_r == OP_SKIP) ? S_SKIP_RD : S_RESULT;
      S_SKIP_RD:  state_nxt = S_RESULT;
      S_REM_HEAD: state_nxt = S_REM_WALK;
      S_REM_WALK: begin
        if (id_hit || walk_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates and slot memory control
  always_comb begin
    op_nxt        = op_r;
    id_nxt        = id_r;
    status_nxt    = status_r;
    ann_nxt       = ann_r;
    fol_nxt       = fol_r;
    size_nxt      = size_r;
    newest_nxt    = newest_r;
    newest_id_nxt = newest_id_r;
    turn_nxt      = turn_r;
    prev_nxt      = prev_r;
    prev_id_nxt   = prev_id_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    free_nxt      = free_r;
    in_use_nxt    = in_use_r;
    we_member     = 1'b0;
    we_link       = 1'b0;
    wr_addr       = '0;
    wr_member     = id_r;
    wr_link       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = op_cmd;
          id_nxt     = id_in;
          status_nxt = ST_OK;
          ann_nxt    = '0;
          fol_nxt    = '0;
          case (op_cmd)
            OP_ADD: begin
              if (ring_full) begin
                status_nxt = ST_FULL;
              end else begin
                // fetch the link after the newest member during the scan
                cnt_nxt = '0;
                rd_en   = 1'b1;
                rd_addr = newest_r;
              end
            end
            OP_REMOVE: begin
              if (ring_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = newest_r;
                prev_nxt    = newest_r;
                prev_id_nxt = newest_id_r;
                n_nxt       = '0;
              end
            end
            default: begin
              if (ring_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = turn_r;
              end
            end
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (free_hit) begin
          // fill the lowest free slot
          we_member         = 1'b1;
          we_link           = 1'b1;
          wr_addr           = cnt_r;
          wr_link           = ring_empty ? cnt_r : rd_link;
          in_use_nxt[cnt_r] = 1'b1;
          if (ring_empty) begin
            turn_nxt      = cnt_r;
            newest_nxt    = cnt_r;
            newest_id_nxt = id_r;
            size_nxt      = size_r + CW'(1);
          end else begin
            free_nxt = cnt_r;
          end
        end else begin
          cnt_nxt = cnt_r + SW'(1);
        end
      end
      S_ADD_FIX: begin
        // link the old newest member to the new slot
        we_link       = 1'b1;
        wr_addr       = newest_r;
        wr_link       = free_r;
        newest_nxt    = free_r;
        newest_id_nxt = id_r;
        size_nxt      = size_r + CW'(1);
      end
      S_TURN_RD: begin
        ann_nxt  = rd_member;
        turn_nxt = rd_link;
        if (op_r == OP_SKIP) begin
          rd_en   = 1'b1;
          rd_addr = rd_link;
        end
      end
      S_SKIP_RD: begin
        fol_nxt  = rd_member;
        turn_nxt = rd_link;
      end
      S_REM_HEAD: begin
        // oldest member follows the newest
        cur_nxt = rd_link;
        rd_en   = 1'b1;
        rd_addr = rd_link;
      end
      S_REM_WALK: begin
        if (id_hit) begin
          in_use_nxt[cur_r] = 1'b0;
          if (size_r == CW'(1)) begin
            size_nxt   = '0;
            newest_nxt = '0;
            turn_nxt   = '0;
          end else begin
            // unlink the matched slot
            we_link = 1'b1;
            wr_addr = prev_r;
            wr_link = rd_link;
            if (cur_r == newest_r) begin
              newest_nxt    = prev_r;
              newest_id_nxt = prev_id_r;
            end
            if (cur_r == turn_r) begin
              turn_nxt = rd_link;
            end
            size_nxt = size_r - CW'(1);
          end
        end else if (walk_last) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          // advance one slot along the ring
          prev_nxt    = cur_r;
          prev_id_nxt = rd_member;
          cur_nxt     = rd_link;
          n_nxt       = n_r + CW'(1);
          rd_en       = 1'b1;
          rd_addr     = rd_link;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      size_r   <= '0;
      newest_r <= '0;
      turn_r   <= '0;
      in_use_r <= '0;
    end else begin
      state_r  <= state_nxt;
      size_r   <= size_nxt;
      newest_r <= newest_nxt;
      turn_r   <= turn_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    status_r    <= status_nxt;
    ann_r       <= ann_nxt;
    fol_r       <= fol_nxt;
    newest_id_r <= newest_id_nxt;
    prev_r      <= prev_nxt;
    prev_id_r   <= prev_id_nxt;
    cur_r       <= cur_nxt;
    cnt_r       <= cnt_nxt;
    n_r         <= n_nxt;
    free_r      <= free_nxt;
  end

  // Result bundle, valid in the result state
  always_comb begin
    result.done         = (state_r == S_RESULT);
    result.status       = status_r;
    result.announced_id = ann_r;
    result.following_id = fol_r;
    result.member_count = COUNT_W'(size_r);
    result.winner_valid = (size_r == CW'(1));
    result.winner_id    = (size_r == CW'(1)) ? newest_id_r : '0;
  end

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CW'(MAX_MEMBERS))
    else $error("ring size beyond capacity");

  // The new slot is marked in the scan state, before the fix state counts it in the size
  a_use_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ADD_FIX) |-> ($countones(in_use_r) == int'(size_r)))
    else $error("slot use bits disagree with ring size");

  a_newest_used: assert property (@(posedge clk) disable iff (!rst_n)
    !ring_empty |-> (in_use_r[newest_r] && in_use_r[turn_r]))
    else $error("newest or turn slot not in use");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM_WALK) |-> (n_r < size_r))
    else $error("remove walk ran past the ring");
`endif

endmodule
